>>> design/itds_pkg.sv
`default_nettype none

package itds_pkg;

  localparam int VALUE_WIDTH_DEF = 31;
  localparam int MAX_DIGITS_DEF  = 32;
  localparam int BITS_PER_CYCLE  = 8;

  localparam int RADIX_W = 6;
  localparam int DIGIT_W = 6;
  localparam int CHAR_W  = 7;
  localparam int PART_W  = RADIX_W + 1;

  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);

  localparam logic [DIGIT_W-1:0] DEC_DIGITS = DIGIT_W'(10);
  localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0]  CHAR_NINE  = 7'h39;
  localparam logic [CHAR_W-1:0]  CHAR_A     = 7'h41;
  localparam logic [CHAR_W-1:0]  CHAR_Z     = 7'h5A;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_FETCH
  } state_e;

  function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    if (r < RADIX_MIN) begin
      res = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      res = RADIX_MAX;
    end else begin
      res = r;
    end
    return res;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] res;
    if (d < DEC_DIGITS) begin
      res = {1'b0, d} + CHAR_ZERO;
    end else begin
      res = {1'b0, d} - {1'b0, DEC_DIGITS} + CHAR_A;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> design/itds_div.sv
`default_nettype none

module itds_div #(
  parameter int VALUE_WIDTH = itds_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [VALUE_WIDTH-1:0]       dividend_i,
  input  wire logic [itds_pkg::RADIX_W-1:0] divisor_i,
  output logic                              done_o,
  output logic [VALUE_WIDTH-1:0]            quotient_o,
  output logic [itds_pkg::RADIX_W-1:0]      remainder_o
);

  localparam int K     = itds_pkg::BITS_PER_CYCLE;
  localparam int STEPS = (VALUE_WIDTH + K - 1) / K;
  localparam int PADW  = STEPS * K;
  localparam int SCW   = $clog2(STEPS + 1);
  localparam int RW    = itds_pkg::RADIX_W;
  localparam int PW    = itds_pkg::PART_W;

  logic [PADW-1:0] acc_q, acc_d;
  logic [RW-1:0]   rem_q, rem_d;
  logic [RW-1:0]   dvs_q;
  logic [SCW-1:0]  cnt_q;
  logic            busy_q;
  logic            done_q;

  always_comb begin
    logic [PW-1:0] part;
    logic          qbit;
    acc_d = acc_q;
    rem_d = rem_q;
    for (int j = 0; j < K; j++) begin
      part = {rem_d, acc_d[PADW-1]};
      if (part >= {1'b0, dvs_q}) begin
        qbit  = 1'b1;
        rem_d = RW'(part - {1'b0, dvs_q});
      end else begin
        qbit  = 1'b0;
        rem_d = part[RW-1:0];
      end
      acc_d = {acc_d[PADW-2:0], qbit};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= SCW'(STEPS);
    end else if (busy_q) begin
      cnt_q <= cnt_q - SCW'(1);
      if (cnt_q == SCW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= PADW'(dividend_i);
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      acc_q <= acc_d;
      rem_q <= rem_d;
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = acc_q[VALUE_WIDTH-1:0];
  assign remainder_o = rem_q;

endmodule

`default_nettype wire

>>> design/itds_dstore.sv
`default_nettype none

module itds_dstore #(
  parameter int DEPTH = itds_pkg::MAX_DIGITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0]     wr_addr_i,
  input  wire logic [itds_pkg::DIGIT_W-1:0] wr_data_i,
  input  wire logic                         rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0]     rd_addr_i,
  output logic [itds_pkg::DIGIT_W-1:0]      rd_data_o
);

  logic [itds_pkg::DIGIT_W-1:0] mem_q [DEPTH];
  logic [itds_pkg::DIGIT_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

>>> design/integer_to_digit_string_top.sv
// Channel  Direction  Handshake               Payload
// in       input      in_valid_i / in_stall_o   value_i
// out      output     out_valid_o / out_stall_i digit_char_o, last_o
// cfg      input      cfg_we_i                  cfg_wdata_i (radix)
//
// Each digit is one division in the shared divider,
// which retires 8 quotient bits a cycle against the radix.
// Each character is then read back, most significant digit first, through the digit store read port.
// Reset restores radix 10; the digit store needs no clearing.
// A stall on out holds the output register; in stays stalled until the last beat is loaded.
`default_nettype none

module integer_to_digit_string_top #(
  parameter int VALUE_WIDTH = itds_pkg::VALUE_WIDTH_DEF,
  parameter int MAX_DIGITS  = itds_pkg::MAX_DIGITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [itds_pkg::RADIX_W-1:0] cfg_wdata_i,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [VALUE_WIDTH-1:0]       value_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [itds_pkg::CHAR_W-1:0]       digit_char_o,
  output logic                              last_o
);

  localparam int AW = $clog2(MAX_DIGITS);
  localparam int CW = $clog2(MAX_DIGITS + 1);
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_DIGITS);

  itds_pkg::state_e state_q, state_d;

  logic [itds_pkg::RADIX_W-1:0] radix_q;
  logic [CW-1:0]                cnt_q, cnt_d;
  logic [AW-1:0]                idx_q, idx_d;
  logic                         out_valid_q;
  logic [itds_pkg::CHAR_W-1:0]  out_char_q;
  logic                         out_last_q;

  logic                         div_start;
  logic [VALUE_WIDTH-1:0]       div_dividend;
  logic                         div_done;
  logic [VALUE_WIDTH-1:0]       div_quot;
  logic [itds_pkg::RADIX_W-1:0] div_rem;

  logic                         wr_en;
  logic                         rd_en;
  logic [itds_pkg::DIGIT_W-1:0] rd_data;
  logic                         load_out;
  logic                         slot_free;

  assign slot_free = !out_valid_q || !out_stall_i;

  itds_div #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (itds_pkg::eff_radix(radix_q)),
    .done_o     (div_done),
    .quotient_o (div_quot),
    .remainder_o(div_rem)
  );

  itds_dstore #(
    .DEPTH(MAX_DIGITS)
  ) u_dstore (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(cnt_q[AW-1:0]),
    .wr_data_i(div_rem),
    .rd_en_i  (rd_en),
    .rd_addr_i(idx_q),
    .rd_data_o(rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= itds_pkg::ST_IDLE;
      cnt_q   <= '0;
      idx_q   <= '0;
      radix_q <= itds_pkg::RADIX_RESET;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      if (cfg_we_i) begin
        radix_q <= cfg_wdata_i;
      end
    end
  end

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    idx_d        = idx_q;
    div_start    = 1'b0;
    div_dividend = value_i;
    wr_en        = 1'b0;
    rd_en        = 1'b0;
    load_out     = 1'b0;
    in_stall_o   = 1'b1;
    unique case (state_q)
      itds_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          div_start = 1'b1;
          cnt_d     = '0;
          state_d   = itds_pkg::ST_DIV;
        end
      end
      itds_pkg::ST_DIV: begin
        div_dividend = div_quot;
        if (div_done) begin
          wr_en = 1'b1;
          cnt_d = cnt_q + CW'(1);
          if (div_quot == '0 || cnt_q + CW'(1) == MaxCnt) begin
            idx_d   = cnt_q[AW-1:0];
            state_d = itds_pkg::ST_READ;
          end else begin
            div_start = 1'b1;
          end
        end
      end
      itds_pkg::ST_READ: begin
        rd_en   = 1'b1;
        state_d = itds_pkg::ST_FETCH;
      end
      itds_pkg::ST_FETCH: begin
        if (slot_free) begin
          load_out = 1'b1;
          if (idx_q == '0) begin
            state_d = itds_pkg::ST_IDLE;
          end else begin
            idx_d   = idx_q - AW'(1);
            state_d = itds_pkg::ST_READ;
          end
        end
      end
      default: begin
        state_d = itds_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_char_q <= itds_pkg::digit_ascii(rd_data);
      out_last_q <= (idx_q == '0);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign digit_char_o = out_char_q;
  assign last_o       = out_last_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= MaxCnt)
    else $error("digit count past store depth");

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == itds_pkg::ST_DIV)
    else $error("divider done outside division phase");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !load_out)
    else $error("output beat overwritten while stalled");

  a_char_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((digit_char_o >= itds_pkg::CHAR_ZERO && digit_char_o <= itds_pkg::CHAR_NINE)
                  || (digit_char_o >= itds_pkg::CHAR_A && digit_char_o <= itds_pkg::CHAR_Z)))
    else $error("digit character out of range");

  a_last_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && idx_q == '0) |=> state_q == itds_pkg::ST_IDLE && out_last_q)
    else $error("last beat loaded without return to idle");

endmodule

`default_nettype wire
